>>> hdl/pidvdt_pkg.sv
// pidvdt_pkg: shared constants, register indexes, state and command types
// for the variable-step PID controller. No dependencies.
package pidvdt_pkg;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

	localparam logic [31:0] MS_PER_S = 32'd1000;

	localparam int TERM_W = 61;
	localparam logic [TERM_W-1:0] TERM_LIMIT = {1'b1, 60'd0};

	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] MUL_LAST = 6'd31;
	localparam logic [CNT_W-1:0] DIV_LAST = 6'd60;

	localparam logic [47:0] OUT_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] OUT_MIN = 48'h8000_0000_0000;
	localparam logic [63:0] ISUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ISUM_MIN = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		SU_IDLE,
		SU_MUL,
		SU_CHECK,
		SU_DIV
	} su_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_ERRTIME,
		ST_ACCUM,
		ST_ILAUNCH,
		ST_WAIT,
		ST_SUM,
		ST_OUT
	} ctl_state_t;

	typedef struct packed {
		logic        start;
		logic        div_en;
		logic [63:0] mcand;
		logic [31:0] mplier;
		logic [31:0] divisor;
	} su_cmd_t;

endpackage

>>> hdl/pidvdt_if.sv
// pidvdt_if: valid/ready channels for config writes, update beats and
// drive beats. Depends on pidvdt_pkg.
interface pidvdt_cfg_if import pidvdt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface pidvdt_in_if ();
	logic               valid;
	logic               ready;
	logic        [31:0] time_ms;
	logic signed [31:0] setpoint;
	logic signed [31:0] measurement;
	modport source (output valid, output time_ms, output setpoint, output measurement,
		input ready);
	modport sink (input valid, input time_ms, input setpoint, input measurement,
		output ready);
endinterface

interface pidvdt_out_if ();
	logic               valid;
	logic               ready;
	logic signed [47:0] actuation;
	modport source (output valid, output actuation, input ready);
	modport sink (input valid, input actuation, output ready);
endinterface

>>> hdl/pidvdt_serial.sv
// pidvdt_serial: bit-serial shift-add multiplier followed by an optional
// restoring divider, with the quotient (or the bare product) clamped to 2^60. Depends on pidvdt_pkg.
module pidvdt_serial import pidvdt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  su_cmd_t           cmd,
	output logic              busy,
	output logic [63:0]       prod,
	output logic [TERM_W-1:0] term_mag
);

	su_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             div_en_q;
	logic [63:0]      mcand_q;
	logic [31:0]      divisor_q;
	logic [95:0]      acc_q;
	logic [31:0]      rem_q;
	logic             sat_q;

	logic [64:0] mul_sum;
	logic [32:0] div_r;
	logic [32:0] div_diff;
	logic        div_ge;
	logic        chk_ovf;
	logic        over;

	assign mul_sum  = {1'b0, acc_q[95:32]} + (acc_q[0] ? {1'b0, mcand_q} : 65'd0);
	assign div_r    = {rem_q, acc_q[60]};
	assign div_diff = div_r - {1'b0, divisor_q};
	assign div_ge   = div_r >= {1'b0, divisor_q};
	assign chk_ovf  = acc_q[95:61] >= {3'b000, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SU_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SU_IDLE: begin
				if (cmd.start) begin
					state_d = SU_MUL;
				end
			end
			SU_MUL: begin
				if (cnt_q == '0) begin
					state_d = div_en_q ? SU_CHECK : SU_IDLE;
				end
			end
			SU_CHECK: begin
				state_d = chk_ovf ? SU_IDLE : SU_DIV;
			end
			SU_DIV: begin
				if (cnt_q == '0) begin
					state_d = SU_IDLE;
				end
			end
			default: state_d = SU_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= MUL_LAST;
		end else if (state_q == SU_CHECK) begin
			cnt_q <= DIV_LAST;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mcand_q   <= cmd.mcand;
			divisor_q <= cmd.divisor;
			div_en_q  <= cmd.div_en;
			acc_q     <= {64'd0, cmd.mplier};
			sat_q     <= 1'b0;
		end else begin
			case (state_q)
				SU_MUL: begin
					acc_q <= {mul_sum, acc_q[31:1]};
				end
				SU_CHECK: begin
					// quotient of 2^61 or more saturates; else preload the remainder
					sat_q        <= chk_ovf;
					rem_q        <= acc_q[92:61];
					acc_q[95:61] <= '0;
				end
				SU_DIV: begin
					rem_q       <= div_ge ? div_diff[31:0] : div_r[31:0];
					acc_q[60:0] <= {acc_q[59:0], div_ge};
				end
				default: ;
			endcase
		end
	end

	assign over     = sat_q || (|acc_q[95:61]) || (acc_q[60] && (|acc_q[59:0]));
	assign term_mag = over ? TERM_LIMIT : acc_q[TERM_W-1:0];
	assign prod     = acc_q[63:0];
	assign busy     = state_q != SU_IDLE;

endmodule

>>> hdl/pid_controller_variable_dt.sv
// pid_controller_variable_dt_top: PID update with a millisecond time step,
// three bit-serial mul/div units. Depends on pidvdt_pkg, pidvdt_if, pidvdt_serial.

// One update beat gives one drive beat; the block takes the next update once that
// result is in the output register. The latency is set by the integral path: a
// 32-step error-time product, then a 32-step gain product and a 61-step quotient
// by 1000 in a bit-serial unit. The proportional and derivative terms run in two
// more units meanwhile.
// Config writes are always ready and must only come while the block is idle.
module pid_controller_variable_dt_top import pidvdt_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	pidvdt_cfg_if.sink   cfg,
	pidvdt_in_if.sink    sample,
	pidvdt_out_if.source drive
);

	ctl_state_t state_q, state_d;

	logic [31:0] gain_p_q, gain_i_q, gain_d_q;
	logic [31:0] last_time_q;
	logic [32:0] last_error_q;
	logic [63:0] isum_q;
	logic        out_valid_q;
	logic [47:0] out_q;

	logic [31:0] dt_q;
	logic [32:0] e_mag_q;
	logic        e_neg_q;
	logic [33:0] de_mag_q;
	logic        de_neg_q;
	logic [62:0] sum_q;

	logic        accept;
	logic [31:0] dt_raw, dt_n;
	logic [32:0] e_n;
	logic [33:0] de_n;
	logic [31:0] gp_mag, gi_mag, gd_mag;
	logic [63:0] isum_mag;
	logic [43:0] de_scaled;
	logic [65:0] s_a, s_b, s_sum;
	logic [63:0] s_sat;
	logic [61:0] p_s, i_s, d_s;
	logic [62:0] sum_d;
	logic [47:0] out_d;
	logic        load_out;

	su_cmd_t cmd0, cmd1, cmd2;
	logic    busy0, busy1, busy2;
	logic [63:0]       prod0;
	logic [TERM_W-1:0] term0, term1, term2;

	pidvdt_serial u_unit0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd0),
		.busy     (busy0),
		.prod     (prod0),
		.term_mag (term0)
	);

	pidvdt_serial u_unit1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd1),
		.busy     (busy1),
		.prod     (),
		.term_mag (term1)
	);

	pidvdt_serial u_unit2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd2),
		.busy     (busy2),
		.prod     (),
		.term_mag (term2)
	);

	assign cfg.ready    = 1'b1;
	assign sample.ready = state_q == ST_IDLE;
	assign accept       = sample.valid && sample.ready;

	assign dt_raw = sample.time_ms - last_time_q;
	assign dt_n   = (dt_raw == 32'd0) ? MS_PER_S : dt_raw;
	assign e_n    = {sample.setpoint[31], sample.setpoint}
		- {sample.measurement[31], sample.measurement};
	assign de_n   = {e_n[32], e_n} - {last_error_q[32], last_error_q};

	assign gp_mag    = gain_p_q[31] ? 32'd0 - gain_p_q : gain_p_q;
	assign gi_mag    = gain_i_q[31] ? 32'd0 - gain_i_q : gain_i_q;
	assign gd_mag    = gain_d_q[31] ? 32'd0 - gain_d_q : gain_d_q;
	assign isum_mag  = isum_q[63] ? 64'd0 - isum_q : isum_q;
	assign de_scaled = {10'd0, de_mag_q} * {12'd0, MS_PER_S};

	// integrator update, saturated to the signed 64-bit range
	assign s_a   = {{2{isum_q[63]}}, isum_q};
	assign s_b   = {2'b00, prod0};
	assign s_sum = e_neg_q ? s_a - s_b : s_a + s_b;
	always_comb begin
		if (s_sum[65:63] == 3'b000 || s_sum[65:63] == 3'b111) begin
			s_sat = s_sum[63:0];
		end else begin
			s_sat = s_sum[65] ? ISUM_MIN : ISUM_MAX;
		end
	end

	assign p_s = (e_neg_q ^ gain_p_q[31]) ? 62'd0 - {1'b0, term1} : {1'b0, term1};
	assign i_s = (isum_q[63] ^ gain_i_q[31]) ? 62'd0 - {1'b0, term0} : {1'b0, term0};
	assign d_s = (de_neg_q ^ gain_d_q[31]) ? 62'd0 - {1'b0, term2} : {1'b0, term2};
	assign sum_d = {p_s[61], p_s} + {i_s[61], i_s} + {d_s[61], d_s};

	always_comb begin
		if (sum_q[62:47] == 16'h0000 || sum_q[62:47] == 16'hFFFF) begin
			out_d = sum_q[47:0];
		end else begin
			out_d = sum_q[62] ? OUT_MIN : OUT_MAX;
		end
	end

	assign load_out = (state_q == ST_OUT) && (!out_valid_q || drive.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd0    = '0;
		cmd1    = '0;
		cmd2    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LAUNCH;
				end
			end
			ST_LAUNCH: begin
				cmd0.start   = 1'b1;
				cmd0.mcand   = {31'd0, e_mag_q};
				cmd0.mplier  = dt_q;
				cmd0.divisor = MS_PER_S;
				cmd1.start   = 1'b1;
				cmd1.mcand   = {31'd0, e_mag_q};
				cmd1.mplier  = gp_mag;
				cmd1.divisor = MS_PER_S;
				cmd2.start   = 1'b1;
				cmd2.div_en  = 1'b1;
				cmd2.mcand   = {20'd0, de_scaled};
				cmd2.mplier  = gd_mag;
				cmd2.divisor = dt_q;
				state_d      = ST_ERRTIME;
			end
			ST_ERRTIME: begin
				if (!busy0) begin
					state_d = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				state_d = ST_ILAUNCH;
			end
			ST_ILAUNCH: begin
				cmd0.start   = 1'b1;
				cmd0.div_en  = 1'b1;
				cmd0.mcand   = isum_mag;
				cmd0.mplier  = gi_mag;
				cmd0.divisor = MS_PER_S;
				state_d      = ST_WAIT;
			end
			ST_WAIT: begin
				if (!busy0 && !busy1 && !busy2) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			last_time_q  <= '0;
			last_error_q <= '0;
			isum_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_GAIN_P: gain_p_q <= cfg.data;
					REG_GAIN_I: gain_i_q <= cfg.data;
					REG_GAIN_D: gain_d_q <= cfg.data;
					default: ;
				endcase
			end
			if (accept) begin
				last_time_q  <= sample.time_ms;
				last_error_q <= e_n;
			end
			if (state_q == ST_ACCUM) begin
				isum_q <= s_sat;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (drive.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dt_q     <= dt_n;
			e_neg_q  <= e_n[32];
			e_mag_q  <= e_n[32] ? 33'd0 - e_n : e_n;
			de_neg_q <= de_n[33];
			de_mag_q <= de_n[33] ? 34'd0 - de_n : de_n;
		end
		if (state_q == ST_SUM) begin
			sum_q <= sum_d;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign drive.valid     = out_valid_q;
	assign drive.actuation = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd0.start |-> !busy0) and (cmd2.start |-> !busy2))
		else $error("serial unit started while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (!busy0 && !busy1 && !busy2))
		else $error("terms summed before all units finished");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACCUM) |-> (!busy0 && !busy1))
		else $error("integrator updated before the error-time product was ready");

endmodule
